>>> src/gradient_value_noise_2d_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 2D lattice noise core
// Clocked property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_VALUE_NOISE_2D_CORE_MACROS_SVH
`define GRADIENT_VALUE_NOISE_2D_CORE_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define GVN_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gvn assertion failed");

// Check a property on every rising edge, reset included.
`define GVN_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gvn assertion failed");

`endif

>>> src/gvn_pkg.sv
// ----------------------------------------------------------------------------
// gvn_pkg
// Shared constants, types and arithmetic helpers of the 2D lattice noise core.
// ----------------------------------------------------------------------------
package gvn_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int FRAC_BITS  = 8;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // Command codes of an input beat.
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  // Noise mode codes.
  typedef enum logic {
    MODE_GRADIENT = 1'b0,
    MODE_VALUE    = 1'b1
  } mode_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic             is_eval;
    logic [IDX_W-1:0] x0;
    logic [IDX_W-1:0] y0;
    logic [15:0]      ux;
    logic [15:0]      uy;
    logic [7:0]       tbl_index;
    logic [7:0]       tbl_value;
  } item_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Corner contribution in Q.16: an axis offset or the hash scaled to [0, 1].
  // The value form uses 65536/255 = 257 + 1/255, so the rounded quotient is
  // h*257 plus one when h is 128 or more.
  function automatic logic signed [17:0] corner_value(
    input logic              mode,
    input logic [7:0]        h,
    input logic signed [17:0] dx,
    input logic signed [17:0] dy
  );
    logic signed [17:0] res;
    if (mode == MODE_VALUE) begin
      res = signed'({2'b00, h, h}) + signed'(18'(h[7]));
    end else begin
      unique case (h[1:0])
        2'd0: res = dx;
        2'd1: res = -dx;
        2'd2: res = -dy;
        default: res = dy;
      endcase
    end
    return res;
  endfunction

  // Linear interpolation a + floor((b - a) * w / 2^16), w in [0, 2^16].
  function automatic logic signed [17:0] lerp_q16(
    input logic signed [17:0] a,
    input logic signed [17:0] b,
    input logic [16:0]        w
  );
    logic signed [18:0] d;
    logic signed [36:0] p;
    d = 19'(b) - 19'(a);
    p = 37'(d) * 37'(signed'({1'b0, w}));
    return 18'(a + 18'(p >>> 16));
  endfunction

endpackage

>>> src/gvn_front.sv
// ----------------------------------------------------------------------------
// gvn_front
// Accepts input beats, splits the point into lattice cell and fraction, and
// holds the classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gvn_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic signed [15:0]  x_coord,
  input  logic signed [15:0]  y_coord,
  input  logic [7:0]          table_index,
  input  logic [7:0]          table_value,
  input  logic                pop,
  output gvn_pkg::queue_head_t head
);
  import gvn_pkg::*;

  item_t      q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      entry;

  // The queue refuses beats only when both entries are taken.
  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;

  // Split each coordinate; the cell wraps by keeping its low index bits.
  always_comb begin
    entry.is_eval   = (cmd == CMD_EVAL);
    entry.x0        = x_coord[FRAC_BITS +: IDX_W];
    entry.y0        = y_coord[FRAC_BITS +: IDX_W];
    entry.ux        = {x_coord[FRAC_BITS-1:0], (16-FRAC_BITS)'(0)};
    entry.uy        = {y_coord[FRAC_BITS-1:0], (16-FRAC_BITS)'(0)};
    entry.tbl_index = table_index;
    entry.tbl_value = table_value;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= entry;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = q_mem[rd_ptr];

endmodule

>>> src/gvn_back.sv
// ----------------------------------------------------------------------------
// gvn_back
// Hash table copies and the evaluation pipeline: hashing, fade curves,
// corner values, bilinear interpolation and the output register.
// ----------------------------------------------------------------------------
module gvn_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 mode,
  input  gvn_pkg::queue_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   noise_value
);
  import gvn_pkg::*;

  // Three copies of the table give the six reads that one item needs.
  logic [7:0] mem_a [TABLE_SIZE];
  logic [7:0] mem_b [TABLE_SIZE];
  logic [7:0] mem_c [TABLE_SIZE];

  logic en;
  logic tbl_we;

  logic             s1_valid;
  logic [IDX_W-1:0] s1_x0, s1_x1;
  logic [15:0]      s1_ux, s1_uy, s1_t2x, s1_t2y;
  logic [7:0]       s1_hy0, s1_hy1;

  logic             s2_valid;
  logic [15:0]      s2_ux, s2_uy, s2_t3x, s2_t3y;
  logic [19:0]      s2_qx, s2_qy;
  logic [7:0]       s2_h00, s2_h10, s2_h01, s2_h11;

  logic               s3_valid;
  logic signed [17:0] s3_a00, s3_a10, s3_a01, s3_a11;
  logic [16:0]        s3_fx, s3_fy;

  logic               s4_valid;
  logic signed [17:0] s4_l0, s4_l1;
  logic [16:0]        s4_fy;

  logic [31:0]        sq_x, sq_y, cu_x, cu_y;
  logic [21:0]        q_x, q_y;
  logic [35:0]        f_x, f_y;
  logic signed [17:0] dx0, dx1, dy0, dy1;
  logic signed [17:0] v;
  logic signed [16:0] half;

  // The pipeline moves as a whole whenever the output register can take a beat.
  assign en     = !(out_valid && out_stall);
  assign pop    = en && head.valid;
  assign tbl_we = pop && !head.item.is_eval
                  && ({1'b0, head.item.tbl_index} < 9'(TABLE_SIZE));

  // Table writes go to every copy, in order with the evaluations.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      mem_a[head.item.tbl_index[IDX_W-1:0]] <= head.item.tbl_value;
      mem_b[head.item.tbl_index[IDX_W-1:0]] <= head.item.tbl_value;
      mem_c[head.item.tbl_index[IDX_W-1:0]] <= head.item.tbl_value;
    end
  end

  // Stage 1: row hashes and squares of the fractions.
  assign sq_x = head.item.ux * head.item.ux;
  assign sq_y = head.item.uy * head.item.uy;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_hy0 <= mem_a[head.item.y0];
      s1_hy1 <= mem_a[IDX_W'(head.item.y0 + 1'b1)];
      s1_x0  <= head.item.x0;
      s1_x1  <= IDX_W'(head.item.x0 + 1'b1);
      s1_ux  <= head.item.ux;
      s1_uy  <= head.item.uy;
      s1_t2x <= sq_x[31:16];
      s1_t2y <= sq_y[31:16];
    end
  end

  // Stage 2: corner hashes, cubes and the quadratic factor of the fade.
  assign cu_x = s1_t2x * s1_ux;
  assign cu_y = s1_t2y * s1_uy;
  assign q_x  = 22'(s1_t2x) * 22'd6 + 22'd655360 - 22'(s1_ux) * 22'd15;
  assign q_y  = 22'(s1_t2y) * 22'd6 + 22'd655360 - 22'(s1_uy) * 22'd15;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_h00 <= mem_b[IDX_W'(s1_x0 + IDX_W'(s1_hy0))];
      s2_h10 <= mem_b[IDX_W'(s1_x1 + IDX_W'(s1_hy0))];
      s2_h01 <= mem_c[IDX_W'(s1_x0 + IDX_W'(s1_hy1))];
      s2_h11 <= mem_c[IDX_W'(s1_x1 + IDX_W'(s1_hy1))];
      s2_ux  <= s1_ux;
      s2_uy  <= s1_uy;
      s2_t3x <= cu_x[31:16];
      s2_t3y <= cu_y[31:16];
      s2_qx  <= q_x[19:0];
      s2_qy  <= q_y[19:0];
    end
  end

  // Stage 3: corner values and fade weights.
  assign dx0 = signed'({2'b00, s2_ux});
  assign dy0 = signed'({2'b00, s2_uy});
  assign dx1 = dx0 - 18'sd65536;
  assign dy1 = dy0 - 18'sd65536;
  assign f_x = s2_t3x * s2_qx;
  assign f_y = s2_t3y * s2_qy;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a00 <= corner_value(mode, s2_h00, dx0, dy0);
      s3_a10 <= corner_value(mode, s2_h10, dx1, dy0);
      s3_a01 <= corner_value(mode, s2_h01, dx0, dy1);
      s3_a11 <= corner_value(mode, s2_h11, dx1, dy1);
      s3_fx  <= f_x[32:16];
      s3_fy  <= f_y[32:16];
    end
  end

  // Stage 4: interpolation along x.
  always_ff @(posedge clk) begin
    if (en) begin
      s4_l0 <= lerp_q16(s3_a00, s3_a10, s3_fx);
      s4_l1 <= lerp_q16(s3_a01, s3_a11, s3_fx);
      s4_fy <= s3_fy;
    end
  end

  // Output: interpolation along y, halving to Q1.15 and saturation at +1.0.
  assign v    = lerp_q16(s4_l0, s4_l1, s4_fy);
  assign half = 17'(v >>> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      noise_value <= (half > 17'sd32767) ? 16'sh7fff : 16'(half);
    end
  end

  // Valid bits of the evaluation stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= pop && head.item.is_eval;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

endmodule

>>> src/gradient_value_noise_2d_core.sv
// ----------------------------------------------------------------------------
// gradient_value_noise_2d_core
// 2D gradient or value lattice noise at a Q8.8 point, result in Q1.15.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  input    in_valid / in_stall   cmd, x_coord, y_coord, table_index,
//                                 table_value
//  output   out_valid / out_stall noise_value
//  config   cfg_wr_en             cfg_wr_data (noise_mode)
//
// One item is taken per cycle while the output is not stalled; an evaluation
// passes through the five pipeline stages behind the queue before it appears.
// Table writes give no result.
// Reset empties the queue and the pipeline; the hash table keeps no reset.
// A stalled output freezes the whole pipeline; the two-entry queue then fills
// and raises in_stall.
// ----------------------------------------------------------------------------
module gradient_value_noise_2d_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [15:0] x_coord,
  input  logic signed [15:0] y_coord,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] noise_value
);
  import gvn_pkg::*;

  logic        noise_mode;
  logic        pop;
  queue_head_t head;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_mode <= MODE_GRADIENT;
    end else if (cfg_wr_en) begin
      noise_mode <= cfg_wr_data;
    end
  end

  gvn_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .table_index (table_index),
    .table_value (table_value),
    .pop         (pop),
    .head        (head)
  );

  gvn_back u_back (
    .clk         (clk),
    .rst         (rst),
    .mode        (noise_mode),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .noise_value (noise_value)
  );

endmodule

>>> src/gvn_checker.sv
// ----------------------------------------------------------------------------
// gvn_checker
// Port-level checks of the noise core, bound to its top level.
// ----------------------------------------------------------------------------
`include "gradient_value_noise_2d_core_macros.svh"

module gvn_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] noise_value
);

  // A stalled result stays offered.
  `GVN_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)

  // A stalled result keeps its value.
  `GVN_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(noise_value))

  // Reset leaves no result pending.
  `GVN_ASSERT_ALWAYS(a_rst_out, rst |=> !out_valid)

  // Reset leaves the queue empty, so input is taken right away.
  `GVN_ASSERT_ALWAYS(a_rst_in, rst |=> !in_stall)

endmodule

bind gradient_value_noise_2d_core gvn_checker u_gvn_checker (.*);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Lattice noise core testbench
// Drives table loads and noise evaluations in gradient and value mode with
// random idle bursts on both channels, predicts each noise beat in a
// scoreboard and compares every output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gvn_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_REPORTS    = 10;

  // Scoreboard: a copy of the hash table and mode, and the predicted beats.
  class noise_scoreboard;
    logic [7:0]   hash_copy [TABLE_SIZE];
    mode_t        mode;
    logic [15:0]  predicted [$];
    int           mismatches;

    function new();
      mode = MODE_GRADIENT;
      mismatches = 0;
      foreach (hash_copy[i]) hash_copy[i] = 8'd0;
    endfunction

    // Quintic easing of a Q.16 fraction.
    function longint ease(longint u);
      longint t2, t3, q;
      t2 = (u * u) >> 16;
      t3 = (t2 * u) >> 16;
      q = 6 * t2 + 10 * 65536 - 15 * u;
      return (t3 * q) >>> 16;
    endfunction

    function longint blend(longint a, longint b, longint w);
      return a + (((b - a) * w) >>> 16);
    endfunction

    function longint corner(int xi, int yi, longint dx, longint dy);
      logic [7:0] h;
      h = hash_copy[(xi + hash_copy[yi]) % TABLE_SIZE];
      if (mode == MODE_VALUE) return (longint'(h) * 65536 + 127) / 255;
      case (h[1:0])
        2'd0: return dx;
        2'd1: return -dx;
        2'd2: return -dy;
        default: return dy;
      endcase
    endfunction

    function logic [15:0] noise_at(logic [15:0] xr, logic [15:0] yr);
      logic [15:0] xb, yb;
      int x0, y0, x1, y1;
      longint ux, uy, fx, fy, v, r;
      // Biasing by half the range makes the cell index wrap on its own.
      xb = xr ^ 16'h8000;
      yb = yr ^ 16'h8000;
      x0 = (int'(xb[15:8]) + 128) % TABLE_SIZE;
      y0 = (int'(yb[15:8]) + 128) % TABLE_SIZE;
      x1 = (x0 + 1) % TABLE_SIZE;
      y1 = (y0 + 1) % TABLE_SIZE;
      ux = longint'(xb[7:0]) << 8;
      uy = longint'(yb[7:0]) << 8;
      fx = ease(ux);
      fy = ease(uy);
      v = blend(blend(corner(x0, y0, ux, uy), corner(x1, y0, ux - 65536, uy), fx),
                blend(corner(x0, y1, ux, uy - 65536),
                      corner(x1, y1, ux - 65536, uy - 65536), fx), fy);
      r = v >>> 1;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
    endfunction

    function void note_input(cmd_t c, logic [15:0] xr, logic [15:0] yr,
                             logic [7:0] idx, logic [7:0] val);
      if (c == CMD_WRITE) hash_copy[idx] = val;
      else predicted.push_back(noise_at(xr, yr));
    endfunction

    function void check_result(logic [15:0] actual);
      logic [15:0] want;
      if (predicted.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected noise beat: actual %0d", $signed(actual));
        return;
      end
      want = predicted.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("noise_value mismatch: expected %0d actual %0d",
                   $signed(want), $signed(actual));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = 1'b0;
  logic signed [15:0] x_coord = '0;
  logic signed [15:0] y_coord = '0;
  logic [7:0]         table_index = '0;
  logic [7:0]         table_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] noise_value;

  noise_scoreboard board = new();
  bit quiet = 1'b0;
  int idle_cycles = 0;

  gradient_value_noise_2d_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd),
    .x_coord(x_coord), .y_coord(y_coord), .table_index(table_index),
    .table_value(table_value), .out_valid(out_valid), .out_stall(out_stall),
    .noise_value(noise_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Output side: sample beats at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(noise_value);
  end

  // Output stall in random bursts, none once the run goes quiet.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one input beat, with a random idle burst ahead of it.
  task automatic send(cmd_t c, logic [15:0] xr, logic [15:0] yr,
                      logic [7:0] idx, logic [7:0] val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    x_coord     <= xr;
    y_coord     <= yr;
    table_index <= idx;
    table_value <= val;
    do @(posedge clk); while (in_stall);
    board.note_input(c, xr, yr, idx, val);
    @(negedge clk);
  endtask

  task automatic eval_at(logic [15:0] xr, logic [15:0] yr);
    send(CMD_EVAL, xr, yr, 8'($urandom()), 8'($urandom()));
  endtask

  // Wait for every predicted beat, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    wait (board.predicted.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(mode_t m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.mode = m;
  endtask

  // Load the whole table with a shuffled permutation.
  task automatic load_permutation();
    logic [7:0] perm [TABLE_SIZE];
    logic [7:0] tmp;
    int j;
    foreach (perm[i]) perm[i] = i[7:0];
    for (int i = TABLE_SIZE - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    foreach (perm[i])
      send(CMD_WRITE, 16'($urandom()), 16'($urandom()), i[7:0], perm[i]);
  endtask

  // Mostly evaluations, some table rewrites, coordinates often near edges.
  task automatic random_items(int count, int quiet_tail);
    logic [15:0] xr, yr;
    for (int k = 0; k < count; k++) begin
      if (k == count - quiet_tail) quiet = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        send(CMD_WRITE, 16'($urandom()), 16'($urandom()), 8'($urandom()),
             8'($urandom()));
      end else begin
        xr = 16'($urandom());
        yr = 16'($urandom());
        if ($urandom_range(0, 3) == 0) xr[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        if ($urandom_range(0, 3) == 0) yr[7:0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        eval_at(xr, yr);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A table of all 255 in value mode gives exactly +1.0, which saturates.
    set_mode(MODE_VALUE);
    for (int i = 0; i < TABLE_SIZE; i++) send(CMD_WRITE, 16'h0, 16'h0, i[7:0], 8'hFF);
    eval_at(16'h0000, 16'h0000);
    eval_at(16'h8000, 16'h7FFF);
    eval_at(16'h1280, 16'hFF40);

    // Directed gradient points: extremes, zero fraction, negative wrap.
    set_mode(MODE_GRADIENT);
    load_permutation();
    eval_at(16'h0000, 16'h0000);
    eval_at(16'h8000, 16'h8000);
    eval_at(16'h7FFF, 16'h7FFF);
    eval_at(16'h8000, 16'h7FFF);
    eval_at(16'hFFFF, 16'hFFFF);
    eval_at(16'h0080, 16'h0080);
    eval_at(16'hFF80, 16'h0140);
    eval_at(16'h00FF, 16'hFF01);
    send(CMD_WRITE, 16'h0, 16'h0, 8'hFF, 8'h00);
    send(CMD_WRITE, 16'h0, 16'h0, 8'h00, 8'hFF);
    eval_at(16'h7F80, 16'h0040);
    eval_at(16'hFF00, 16'h0100);
    random_items(100, 0);

    set_mode(MODE_VALUE);
    eval_at(16'h8000, 16'h8000);
    eval_at(16'h7FFF, 16'h7FFF);
    random_items(80, 0);

    set_mode(MODE_GRADIENT);
    random_items(60, 40);

    drain();
    if (board.mismatches == 0 && board.predicted.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/gvn_pkg.sv
src/gvn_front.sv
src/gvn_back.sv
src/gradient_value_noise_2d_core.sv
src/gvn_checker.sv
tb/sv/tb.sv
